>>> hw/rtl/matrix4x4_multiply_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix product engine.
// Both macros sample on the rising edge of clk and stay quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX4X4_MULTIPLY_MACROS_SVH
`define MATRIX4X4_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM4_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types of the 4x4 fixed-point matrix product engine.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int DIM        = 4;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = $clog2(DIM);
	localparam int ELEM_W     = 32;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int SUM_W      = PROD_W + $clog2(DIM);
	localparam int FIELDS_W   = 2 * IDX_W + ELEM_W;
	localparam int DATA_W     = ((FIELDS_W + 7) / 8) * 8;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USER_W = 1;

	// Bit positions inside the slave-side tuser.
	localparam int USER_SEL   = 0;
	localparam int USER_START = 1;

	typedef struct packed {
		logic              a_en;
		logic              b_en;
		logic [IDX_W-1:0]  addr;
		logic [ELEM_W-1:0] data;
	} mm4_wr_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [SUM_W-1:0]  sum;
	} mm4_tok_t;

endpackage

>>> hw/rtl/mm4_cell.sv
// ----------------------------------------------------------------------------
// mm4_cell
// One cell of the product chain. It holds column k of A and row k of B,
// multiplies the pair selected by the passing request and adds the product
// to the running sum before handing it to the next cell.
// ----------------------------------------------------------------------------
module mm4_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  mm4_pkg::mm4_wr_t  wr,
	input  mm4_pkg::mm4_tok_t tok_in,
	output mm4_pkg::mm4_tok_t tok_out
);
	import mm4_pkg::*;

	logic [ELEM_W-1:0] a_q [DIM];
	logic [ELEM_W-1:0] b_q [DIM];
	mm4_tok_t          tok_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]  prod_ext;

	always_ff @(posedge clk) begin
		if (wr.a_en) begin
			a_q[wr.addr] <= wr.data;
		end
		if (wr.b_en) begin
			b_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= PROD_W'($signed(a_q[tok_in.row]) * $signed(b_q[tok_in.col]));
		end
	end

	assign prod_ext = {{(SUM_W - PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_out <= '0;
		end else if (adv) begin
			tok_s1        <= tok_in;
			tok_out.valid <= tok_s1.valid;
			tok_out.last  <= tok_s1.last;
			tok_out.row   <= tok_s1.row;
			tok_out.col   <= tok_s1.col;
			tok_out.sum   <= tok_s1.sum + prod_ext;
		end
	end

endmodule

>>> hw/rtl/mm4_out.sv
// ----------------------------------------------------------------------------
// mm4_out
// Scales the finished sum down by the fraction width with a floor shift,
// saturates it to 32 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module mm4_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mm4_pkg::mm4_tok_t           tok_in,
	output logic                        adv,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mm4_pkg::DATA_W-1:0]     m_axis_tdata,  // row, column, value, zero fill
	output logic [mm4_pkg::OUT_USER_W-1:0] m_axis_tuser,  // saturated flag
	output logic                        m_axis_tlast
);
	import mm4_pkg::*;

	logic [SUM_W-1:0]  shifted;
	logic              fits;
	logic [ELEM_W-1:0] value;
	logic              valid_q;
	logic              last_q;
	logic              sat_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [ELEM_W-1:0] value_q;

	assign shifted = SUM_W'($signed(tok_in.sum) >>> FRAC_BITS);
	assign fits    = (&shifted[SUM_W-1:ELEM_W-1]) | ~(|shifted[SUM_W-1:ELEM_W-1]);

	always_comb begin
		if (fits) begin
			value = shifted[ELEM_W-1:0];
		end else if (shifted[SUM_W-1]) begin
			value = {1'b1, {(ELEM_W - 1){1'b0}}};
		end else begin
			value = {1'b0, {(ELEM_W - 1){1'b1}}};
		end
	end

	assign adv = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.valid) begin
			last_q  <= tok_in.last;
			sat_q   <= !fits;
			row_q   <= tok_in.row;
			col_q   <= tok_in.col;
			value_q <= value;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(DATA_W - FIELDS_W){1'b0}}, value_q, col_q, row_q};
	assign m_axis_tuser  = sat_q;
	assign m_axis_tlast  = last_q;

endmodule

>>> hw/rtl/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Element writes are taken back to back while no start request is in progress.
// A start request issues 16 products into a chain of 4 cells, two stages each;
// the results then leave one a cycle while m_axis_tready stays high.
// A start request keeps the block busy, refusing writes, until its last result is taken.
// Reset clears the sequencer and the valid bits; the matrices are not cleared.
// ----------------------------------------------------------------------------
`include "matrix4x4_multiply_macros.svh"

module matrix4x4_multiply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [mm4_pkg::DATA_W-1:0]     s_axis_tdata,  // row, column, value, zero fill
	input  logic [mm4_pkg::IN_USER_W-1:0]  s_axis_tuser,  // operand select, start
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [mm4_pkg::DATA_W-1:0]     m_axis_tdata,  // row, column, value, zero fill
	output logic [mm4_pkg::OUT_USER_W-1:0] m_axis_tuser,  // saturated flag
	output logic                        m_axis_tlast
);
	import mm4_pkg::*;

	logic              wr_en;
	logic              sel;
	logic              start;
	logic [IDX_W-1:0]  wr_row;
	logic [IDX_W-1:0]  wr_col;
	logic [ELEM_W-1:0] wr_data;
	logic              in_range;
	logic              adv;
	logic              busy_q;
	logic              issuing_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic              row_end;
	logic              col_end;
	logic              done;
	mm4_wr_t           wr [DIM];
	mm4_tok_t          tok [DIM + 1];

	assign s_axis_tready = !busy_q;
	assign wr_en    = s_axis_tvalid && s_axis_tready;
	assign sel      = s_axis_tuser[USER_SEL];
	assign start    = s_axis_tuser[USER_START];
	assign wr_row   = s_axis_tdata[IDX_W-1:0];
	assign wr_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign wr_data  = s_axis_tdata[FIELDS_W-1:2*IDX_W];
	assign in_range = (32'(wr_row) < DIM) && (32'(wr_col) < DIM);

	// Element A[r][c] lives in cell c, element B[r][c] in cell r.
	for (genvar k = 0; k < DIM; k++) begin : g_wr
		assign wr[k].a_en = wr_en && in_range && !sel && (wr_col == IDX_W'(k));
		assign wr[k].b_en = wr_en && in_range && sel && (wr_row == IDX_W'(k));
		assign wr[k].addr = sel ? wr_col : wr_row;
		assign wr[k].data = wr_data;
	end

	assign row_end = (row_q == IDX_W'(DIM - 1));
	assign col_end = (col_q == IDX_W'(DIM - 1));
	assign done    = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			issuing_q <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
		end else begin
			if (wr_en && start) begin
				busy_q    <= 1'b1;
				issuing_q <= 1'b1;
				row_q     <= '0;
				col_q     <= '0;
			end else if (issuing_q && adv) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
					if (row_end) begin
						issuing_q <= 1'b0;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok[0].valid = issuing_q;
	assign tok[0].last  = row_end && col_end;
	assign tok[0].row   = row_q;
	assign tok[0].col   = col_q;
	assign tok[0].sum   = '0;

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		mm4_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.wr      (wr[k]),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	mm4_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.tok_in        (tok[DIM]),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	`MM4_ASSERT_SAME(a_out_busy, m_axis_tvalid, busy_q, "result shown while idle")
	`MM4_ASSERT_SAME(a_issue_busy, issuing_q, busy_q, "issuing while idle")
	`MM4_ASSERT_NEXT(a_start_busy, wr_en && start, busy_q, "start request did not set busy")
	`MM4_ASSERT_NEXT(a_done_idle, done, !busy_q && !issuing_q, "block still busy after last")
	`MM4_ASSERT_SAME(a_last_pos, m_axis_tvalid && m_axis_tlast,
		m_axis_tdata[IDX_W-1:0] == IDX_W'(DIM - 1) &&
		m_axis_tdata[2*IDX_W-1:IDX_W] == IDX_W'(DIM - 1), "last marked on wrong element")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 fixed-point matrix product engine. Element
// write requests are queued up front and sent in bursts of random length. The
// bench keeps its own copy of both matrices and, for each start request,
// predicts all sixteen product elements. The receiver stalls in changing
// patterns. It holds off once for a long stretch, and the sender drains up to twice.
// ----------------------------------------------------------------------------
module tb_top;
	import mm4_pkg::*;

	localparam int ROW_LSB         = 0;
	localparam int COL_LSB         = IDX_W;
	localparam int VAL_LSB         = 2 * IDX_W;
	localparam int RANDOM_REQUESTS = 415;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 60;
	localparam int LONG_HOLD       = 300;
	localparam int HOLD_AFTER      = 120;

	localparam logic signed [SUM_W-1:0] POS_LIMIT = 32'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] NEG_LIMIT = -POS_LIMIT - 1;

	localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
	localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
	localparam logic [ELEM_W-1:0] ELEM_ONE = 32'h0001_0000;

	typedef enum logic {OPERAND_A = 1'b0, OPERAND_B = 1'b1} operand_e;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

	typedef struct {
		operand_e          sel;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
		logic              start;
		logic              drain_first;
	} request_t;

	typedef struct {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ELEM_W-1:0] value;
		logic              saturated;
		logic              last;
	} element_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DATA_W-1:0]     m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	request_t          request_q[$];
	element_t          product_q[$];
	request_t          on_bus;
	logic [ELEM_W-1:0] a_elem[DIM*DIM];
	logic [ELEM_W-1:0] b_elem[DIM*DIM];

	int       cycle_count      = 0;
	int       mismatches       = 0;
	int       writes_accepted  = 0;
	int       products_started = 0;
	int       elements_checked = 0;
	int       saturated_seen   = 0;
	int       input_stalls     = 0;
	int       output_holds     = 0;
	int       burst_left       = 0;
	int       gap_left         = 0;
	int       hold_left        = 0;
	int       mode_left        = 0;
	bit       long_hold_done   = 1'b0;
	bit       drain_next       = 1'b0;
	rx_mode_e rx_mode          = RX_OPEN;

	matrix4x4_multiply uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic [ELEM_W-1:0] pick_value(bit narrow);
		int v;
		if (narrow && $urandom_range(0, 9) < 8) begin
			v = int'($urandom_range(0, 524287)) - 262144;
			return v;
		end
		case ($urandom_range(0, 5))
			0: return ELEM_MAX;
			1: return ELEM_MIN;
			2: return '0;
			3: begin
				case ($urandom_range(0, 2))
					0: return 32'h0000_0001;
					1: return 32'hFFFF_FFFF;
					default: return ELEM_ONE;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic push_request(operand_e sel, int row, int col, logic [ELEM_W-1:0] value,
			logic start);
		request_t r;
		r.sel         = sel;
		r.row         = IDX_W'(row);
		r.col         = IDX_W'(col);
		r.value       = value;
		r.start       = start;
		r.drain_first = drain_next;
		drain_next    = 1'b0;
		request_q.push_back(r);
	endtask

	task automatic fill_matrix(operand_e sel, bit narrow, bit start_at_end);
		for (int i = 0; i < DIM * DIM; i++) begin
			push_request(sel, i / DIM, i % DIM, pick_value(narrow),
				start_at_end && i == DIM * DIM - 1);
		end
	endtask

	// Updates the local copy of the matrices and, on a start request, queues
	// the sixteen product elements in row-major order.
	task automatic apply_request(request_t r);
		logic signed [ELEM_W-1:0] lhs, rhs;
		logic signed [SUM_W-1:0]  acc, wide_l, wide_r, scaled;
		element_t                 e;
		if (r.sel == OPERAND_B) begin
			b_elem[r.row * DIM + r.col] = r.value;
		end else begin
			a_elem[r.row * DIM + r.col] = r.value;
		end
		writes_accepted++;
		if (r.start) begin
			products_started++;
			for (int i = 0; i < DIM; i++) begin
				for (int j = 0; j < DIM; j++) begin
					acc = '0;
					for (int k = 0; k < DIM; k++) begin
						lhs    = a_elem[i * DIM + k];
						rhs    = b_elem[k * DIM + j];
						wide_l = lhs;
						wide_r = rhs;
						acc    = acc + wide_l * wide_r;
					end
					scaled = acc >>> FRAC_BITS;
					e.row  = IDX_W'(i);
					e.col  = IDX_W'(j);
					e.last = (i == DIM - 1 && j == DIM - 1);
					if (scaled > POS_LIMIT) begin
						e.value     = ELEM_MAX;
						e.saturated = 1'b1;
					end else if (scaled < NEG_LIMIT) begin
						e.value     = ELEM_MIN;
						e.saturated = 1'b1;
					end else begin
						e.value     = scaled[ELEM_W-1:0];
						e.saturated = 1'b0;
					end
					if (e.saturated) begin
						saturated_seen++;
					end
					product_q.push_back(e);
				end
			end
		end
	endtask

	task automatic report(string field, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
		$display("%0t: product %s wrong, expected %h, actual %h", $time, field, want, got);
		mismatches++;
	endtask

	task automatic check_element();
		element_t want;
		element_t got;
		got.row       = m_axis_tdata[ROW_LSB +: IDX_W];
		got.col       = m_axis_tdata[COL_LSB +: IDX_W];
		got.value     = m_axis_tdata[VAL_LSB +: ELEM_W];
		got.saturated = m_axis_tuser[0];
		got.last      = m_axis_tlast;
		elements_checked++;
		if (product_q.size() == 0) begin
			$display("%0t: product element with none pending, expected none, actual %h",
				$time, m_axis_tdata);
			mismatches++;
		end else begin
			want = product_q.pop_front();
			if (got.row !== want.row) begin
				report("row", ELEM_W'(want.row), ELEM_W'(got.row));
			end
			if (got.col !== want.col) begin
				report("column", ELEM_W'(want.col), ELEM_W'(got.col));
			end
			if (got.value !== want.value) begin
				report("value", want.value, got.value);
			end
			if (got.saturated !== want.saturated) begin
				report("saturation flag", ELEM_W'(want.saturated), ELEM_W'(got.saturated));
			end
			if (got.last !== want.last) begin
				report("last flag", ELEM_W'(want.last), ELEM_W'(got.last));
			end
		end
	endtask

	// Sender: requests go out in bursts with gaps between them. A request
	// marked drain_first waits until every pending product element is back.
	always @(posedge clk or negedge arst_n) begin
		logic                 offer;
		logic [DATA_W-1:0]    word;
		logic [IN_USER_W-1:0] user;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_request(on_bus);
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				input_stalls++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() > 0 &&
						!(request_q[0].drain_first && product_q.size() > 0)) begin
					offer  = 1'b1;
					on_bus = request_q.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end
					if (burst_left == 0) begin
						gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 16);
					end
				end
				s_axis_tvalid <= offer;
				if (offer) begin
					word = '0;
					word[ROW_LSB +: IDX_W]  = on_bus.row;
					word[COL_LSB +: IDX_W]  = on_bus.col;
					word[VAL_LSB +: ELEM_W] = on_bus.value;
					user = '0;
					user[USER_SEL]   = on_bus.sel;
					user[USER_START] = on_bus.start;
					s_axis_tdata <= word;
					s_axis_tuser <= user;
				end
			end
		end
	end

	// Receiver: checks each element taken and picks the next ready value from
	// a stall pattern that changes every so often, with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		logic ready;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_element();
			end
			if (m_axis_tvalid && !m_axis_tready) begin
				output_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready = 1'b0;
			end else if (!long_hold_done && elements_checked >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
				ready          = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_OPEN:     ready = 1'b1;
					RX_RANDOM:   ready = ($urandom_range(0, 3) != 0);
					RX_PERIODIC: ready = (cycle_count % 3 != 0);
					default:     ready = ($urandom_range(0, 9) < 3);
				endcase
			end
			m_axis_tready <= ready;
		end
	end

	initial begin
		int          kind;
		int          n;
		int          seq;
		int          directed_n;
		bit          narrow;
		logic [ELEM_W-1:0] col3_val[DIM];

		// Directed part. A holds the most negative value everywhere; the columns
		// of B give positive saturation beyond 64 bits, negative saturation and
		// zero, and the last column mixes small values. Every element is written
		// before the first start.
		col3_val = '{32'h0000_0001, 32'hFFFF_FFFF, ELEM_ONE, 32'h0000_0003};
		for (int i = 0; i < DIM * DIM; i++) begin
			push_request(OPERAND_A, i / DIM, i % DIM, ELEM_MIN, 1'b0);
		end
		for (int r = 0; r < DIM; r++) begin
			push_request(OPERAND_B, r, 0, ELEM_MIN, 1'b0);
			push_request(OPERAND_B, r, 1, ELEM_MAX, 1'b0);
			push_request(OPERAND_B, r, 2, '0, 1'b0);
			push_request(OPERAND_B, r, 3, col3_val[r], r == DIM - 1);
		end
		push_request(OPERAND_A, 0, 0, 32'h0000_0001, 1'b1);
		push_request(OPERAND_A, 1, 1, 32'hFFFF_FFFF, 1'b1);
		push_request(OPERAND_B, 3, 0, '0, 1'b1);
		directed_n = request_q.size();

		// Random part: mostly short write sequences ending in a start, with
		// full refills of small values so that unsaturated results are common.
		seq = 0;
		while (request_q.size() < directed_n + RANDOM_REQUESTS) begin
			if (seq == 8 || seq == 30) begin
				drain_next = 1'b1;
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: begin
					fill_matrix(OPERAND_A, 1'b1, 1'b0);
					fill_matrix(OPERAND_B, 1'b1, 1'b1);
				end
				2: begin
					fill_matrix(operand_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'b1);
				end
				default: begin
					n      = $urandom_range(1, 6);
					narrow = ($urandom_range(0, 3) != 0);
					for (int i = 0; i < n; i++) begin
						push_request(operand_e'($urandom_range(0, 1)), $urandom_range(0, 3),
							$urandom_range(0, 3), pick_value(narrow),
							kind != 3 && i == n - 1);
					end
				end
			endcase
			seq++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (request_q.size() == 0 && !s_axis_tvalid);
		wait (product_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d element writes and %0d product requests; checked %0d elements,",
			writes_accepted, products_started, elements_checked);
		$display("%0d of them saturated; input stalled %0d cycles, output held %0d cycles.",
			saturated_seen, input_stalls, output_holds);
		if (mismatches == 0) begin
			$display("matrix4x4_multiply: match");
		end else begin
			$display("matrix4x4_multiply: mismatch");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run stopped after %0d cycles", $time, cycle_count);
		$display("matrix4x4_multiply: mismatch");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_cell.sv
hw/rtl/mm4_out.sv
hw/rtl/matrix4x4_multiply.sv
bench/tb_top.sv
